/* rtl/core/json_string_unescape_top_assert.svh */
// ============================================================================
// JSON string unescape assertion macros
// Shared concurrent assertion forms clocked on aclk.
// ============================================================================
`ifndef JSON_STRING_UNESCAPE_TOP_ASSERT_SVH
`define JSON_STRING_UNESCAPE_TOP_ASSERT_SVH

// Assertion that is switched off while reset is asserted.
`define JSU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Assertion that is also checked across reset.
`define JSU_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/core/jsu_pkg.sv */
// ============================================================================
// JSON string unescape package
// Payload types, decoder result bundle and error codes shared by the block.
// ============================================================================
package jsu_pkg;

    // Error codes carried on the final result of an input byte.
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
    localparam logic [2:0] ERR_ESCAPE   = 3'd2;
    localparam logic [2:0] ERR_HEX      = 3'd3;
    localparam logic [2:0] ERR_UNTERM   = 3'd4;

    // Most results that one input byte can cause.
    localparam int MAX_RESULTS = 3;

    // Input transfer payload.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_t;

    // Output transfer payload.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_done;
        logic [2:0] error_code;
        logic       last;
    } res_t;

    // All results of one input byte, oldest in entry 0.
    typedef struct packed {
        res_t [MAX_RESULTS-1:0] res;
        logic [1:0]             cnt;
    } dec_t;

endpackage

/* rtl/core/json_string_unescape_top.sv */
// ============================================================================
// JSON string unescape top level
// Streaming decoder for one quoted JSON string, one text byte per transfer.
// ============================================================================
// Usage: the s_ channel takes one text byte per transfer, starting with the
// opening quote; s_data.end_of_text marks the last byte of the text. The m_
// channel gives one result per transfer: a decoded byte and, on the final
// result of an input byte, the string_done flag or an error code.
// An input byte causes zero to three results, which pass through a result
// holding stage and then the output register to the m_ ports. The decoder sits
// between the input and the holding stage; a byte is taken every cycle
// as long as earlier bytes gave at most one result each and the receiver
// keeps m_ready high. A \u escape that yields two or three UTF-8 bytes holds
// s_ready low while the holding stage drains through the single output
// register.
// When the receiver stalls, the output register and the holding stage keep
// their contents, and s_ready falls once both are full.
// Reset clears the scan state to wait for an opening quote and empties both
// stages; no results are pending afterward.
// ============================================================================
module json_string_unescape_top
    import jsu_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_data
);

    dec_t                   dec;
    logic                   s_fire;
    logic                   out_load;
    logic                   move;
    logic                   hold_vld_reg, hold_vld_next;
    logic [1:0]             hold_cnt_reg, hold_cnt_next;
    res_t [MAX_RESULTS-1:0] hold_res_reg, hold_res_next;
    logic                   m_valid_reg, m_valid_next;
    res_t                   m_data_reg, m_data_next;

    jsu_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (s_fire),
        .in_item (s_data),
        .dec     (dec)
    );

    // The output register can load when empty or when its transfer completes.
    assign out_load = !m_valid_reg || m_ready;
    assign move     = hold_vld_reg && out_load;
    assign s_ready  = !hold_vld_reg || (hold_cnt_reg == 2'd1 && out_load);
    assign s_fire   = s_valid && s_ready;

    // Holding stage shifts its oldest result into the output register.
    always_comb begin
        hold_vld_next = hold_vld_reg;
        hold_cnt_next = hold_cnt_reg;
        hold_res_next = hold_res_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (move) begin
            m_valid_next  = 1'b1;
            m_data_next   = hold_res_reg[0];
            hold_res_next = {hold_res_reg[MAX_RESULTS-1], hold_res_reg[MAX_RESULTS-1:1]};
            hold_cnt_next = hold_cnt_reg - 2'd1;
            hold_vld_next = (hold_cnt_reg != 2'd1);
        end else if (out_load) begin
            m_valid_next = 1'b0;
        end

        if (s_fire && dec.cnt != 2'd0) begin
            hold_vld_next = 1'b1;
            hold_cnt_next = dec.cnt;
            hold_res_next = dec.res;
        end
    end

    // Valid flags are reset; payload registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            hold_vld_reg <= hold_vld_next;
            m_valid_reg  <= m_valid_next;
        end
        hold_cnt_reg <= hold_cnt_next;
        hold_res_reg <= hold_res_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/core/jsu_decode.sv */
// ============================================================================
// JSON string unescape decoder
// Holds the scan state and turns one input byte into zero to three results.
// ============================================================================
module jsu_decode
    import jsu_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic advance,
    input  in_t  in_item,
    output dec_t dec
);

    typedef enum logic [1:0] {PH_IDLE, PH_STR, PH_ESC, PH_HEX} phase_t;

    localparam logic [7:0]  CH_QUOTE   = 8'h22;
    localparam logic [7:0]  CH_BSLASH  = 8'h5C;
    localparam logic [7:0]  CH_SLASH   = 8'h2F;
    localparam logic [7:0]  CH_B       = 8'h62;
    localparam logic [7:0]  CH_F       = 8'h66;
    localparam logic [7:0]  CH_N       = 8'h6E;
    localparam logic [7:0]  CH_R       = 8'h72;
    localparam logic [7:0]  CH_T       = 8'h74;
    localparam logic [7:0]  CH_U       = 8'h75;
    localparam logic [15:0] UTF8_LIM1  = 16'h0080;
    localparam logic [15:0] UTF8_LIM2  = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;

    phase_t      phase_reg, phase_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [15:0] code_accum_reg, code_accum_next;

    // Hex digit value with a valid flag in the top bit.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, 4'(b[3:0] + 4'd9)};
        end
        return r;
    endfunction

    // Decode of the presented byte against the current scan state.
    always_comb begin
        logic [4:0]       hd;
        logic [15:0]      acc_shift;
        logic [2:0][7:0]  bytes;
        logic [1:0]       nb;
        logic             done;
        logic [2:0]       err;
        logic [1:0]       cnt;
        logic             fin;
        logic             bv;

        hd              = hex_digit(in_item.in_byte);
        acc_shift       = {code_accum_reg[11:0], hd[3:0]};
        bytes           = '0;
        nb              = 2'd0;
        done            = 1'b0;
        err             = ERR_NONE;
        phase_next      = phase_reg;
        hex_count_next  = hex_count_reg;
        code_accum_next = code_accum_reg;

        unique case (phase_reg)
            PH_IDLE: begin
                if (in_item.in_byte == CH_QUOTE) begin
                    phase_next = PH_STR;
                end else begin
                    err = ERR_NO_QUOTE;
                end
            end
            PH_STR: begin
                if (in_item.in_byte == CH_QUOTE) begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end else if (in_item.in_byte == CH_BSLASH) begin
                    phase_next = PH_ESC;
                end else begin
                    bytes[0] = in_item.in_byte;
                    nb       = 2'd1;
                end
            end
            PH_ESC: begin
                phase_next = PH_STR;
                nb         = 2'd1;
                case (in_item.in_byte)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: bytes[0] = in_item.in_byte;
                    CH_B: bytes[0] = 8'h08;
                    CH_F: bytes[0] = 8'h0C;
                    CH_N: bytes[0] = 8'h0A;
                    CH_R: bytes[0] = 8'h0D;
                    CH_T: bytes[0] = 8'h09;
                    CH_U: begin
                        nb              = 2'd0;
                        phase_next      = PH_HEX;
                        hex_count_next  = 2'd0;
                        code_accum_next = 16'd0;
                    end
                    default: begin
                        nb         = 2'd0;
                        err        = ERR_ESCAPE;
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            PH_HEX: begin
                if (!hd[4]) begin
                    err        = ERR_HEX;
                    phase_next = PH_IDLE;
                end else if (hex_count_reg == 2'd3) begin
                    // Fourth digit: emit the unit as UTF-8.
                    if (acc_shift < UTF8_LIM1) begin
                        bytes[0] = acc_shift[7:0];
                        nb       = 2'd1;
                    end else if (acc_shift < UTF8_LIM2) begin
                        bytes[0] = UTF8_LEAD2 | {3'b000, acc_shift[10:6]};
                        bytes[1] = UTF8_CONT | {2'b00, acc_shift[5:0]};
                        nb       = 2'd2;
                    end else begin
                        bytes[0] = UTF8_LEAD3 | {4'b0000, acc_shift[15:12]};
                        bytes[1] = UTF8_CONT | {2'b00, acc_shift[11:6]};
                        bytes[2] = UTF8_CONT | {2'b00, acc_shift[5:0]};
                        nb       = 2'd3;
                    end
                    phase_next      = PH_STR;
                    hex_count_next  = 2'd0;
                    code_accum_next = 16'd0;
                end else begin
                    hex_count_next  = hex_count_reg + 2'd1;
                    code_accum_next = acc_shift;
                end
            end
            default: phase_next = PH_IDLE;
        endcase

        // Text that ends with the string still open is unterminated.
        if (in_item.end_of_text && phase_next != PH_IDLE) begin
            if (err == ERR_NONE) begin
                err = ERR_UNTERM;
            end
            phase_next = PH_IDLE;
        end
        if (phase_next == PH_IDLE) begin
            hex_count_next  = 2'd0;
            code_accum_next = 16'd0;
        end

        // A status-only outcome still needs one result.
        cnt = (nb == 2'd0 && (done || err != ERR_NONE)) ? 2'd1 : nb;

        for (int k = 0; k < MAX_RESULTS; k++) begin
            fin = (2'(k) == cnt - 2'd1);
            bv  = (2'(k) < nb);
            dec.res[k].out_byte    = bv ? bytes[k] : 8'h00;
            dec.res[k].byte_valid  = bv;
            dec.res[k].string_done = fin & done;
            dec.res[k].error_code  = fin ? err : ERR_NONE;
            dec.res[k].last        = fin;
        end
        dec.cnt = cnt;
    end

    // Scan state advances on every accepted input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            hex_count_reg  <= 2'd0;
            code_accum_reg <= 16'd0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            hex_count_reg  <= hex_count_next;
            code_accum_reg <= code_accum_next;
        end
    end

endmodule

/* rtl/core/jsu_checker.sv */
// ============================================================================
// JSON string unescape port checker
// Watches the top-level ports and checks result framing over time.
// ============================================================================
`include "json_string_unescape_top_assert.svh"

module jsu_checker
    import jsu_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input res_t m_data
);

    // A stalled result transfer keeps its payload.
    `JSU_ASSERT(a_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed under stall")

    // Reset leaves no result pending.
    `JSU_ASSERT_RST(a_reset, !aresetn |=> !m_valid, "result valid after reset")

    // Status travels only on the final result of an input byte.
    `JSU_ASSERT(a_status_last, m_valid && (m_data.string_done || m_data.error_code != ERR_NONE) |-> m_data.last, "status on a non-final result")

    // A result with no byte is a status-only result.
    `JSU_ASSERT(a_empty_result, m_valid && !m_data.byte_valid |-> m_data.last && m_data.out_byte == 8'h00 && (m_data.string_done || m_data.error_code != ERR_NONE), "empty result without status")

    // Success and error never appear together, and codes stay in range.
    `JSU_ASSERT(a_status_range, m_valid |-> !(m_data.string_done && m_data.error_code != ERR_NONE) && m_data.error_code <= ERR_UNTERM, "bad status combination")

endmodule

bind json_string_unescape_top jsu_checker u_jsu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* sim/tb_json_string_unescape_top.sv */
// ============================================================================
// JSON string unescape testbench
// Feeds quoted JSON text one byte per transfer and compares every result
// transfer against a cycle-free decoder model kept inside the bench. A short
// directed run covers a simple and an unknown escape, the UTF-8 lengths and
// each error; random strings follow, mostly well formed, with broken endings
// and stray bytes. Both channels idle and stall at random.
// ============================================================================
module tb_json_string_unescape_top;
    import jsu_pkg::*;

    // Character codes that steer the decoder.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Scan state of the decoder model.
    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_STR,
        SCAN_ESC,
        SCAN_HEX
    } scan_e;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    res_t m_data;

    // Text bytes waiting to be sent and decoded results still to arrive.
    in_t   text_q[$];
    res_t  decoded_q[$];

    // Decoder model state.
    scan_e       scan_state = SCAN_IDLE;
    logic [1:0]  hex_taken  = '0;
    logic [15:0] code_acc   = '0;

    int   error_count = 0;
    int   result_count = 0;
    int   in_draws = 0;
    int   out_draws = 0;
    int   gap_cnt = 0;
    int   hold_cnt = 0;
    int   next_hold;
    res_t want;

    json_string_unescape_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Free-running clock, period 10.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Prints one mismatch line (only the first few) and counts it.
    task automatic report_mismatch(string what);
        if (error_count < 40) begin
            $display("MISMATCH: %s", what);
        end
        error_count++;
    endtask

    function automatic bit is_hex_digit(logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    // Idle cycles before the next transfer; every third stretch runs flat out.
    function automatic int pick_delay(int n);
        return ((n / 40) % 3 == 2) ? 0 : $urandom_range(0, 11);
    endfunction

    // Decodes one text byte and queues the results it should produce.
    function automatic void predict_decoded(in_t item);
        logic [7:0]  b;
        logic [7:0]  dec [0:2];
        logic [15:0] acc;
        logic        done;
        logic [2:0]  err;
        int          nb;
        int          cnt;
        int          digit;
        res_t        r;
        b     = item.in_byte;
        nb    = 0;
        done  = 1'b0;
        err   = ERR_NONE;
        digit = -1;
        case (scan_state)
            SCAN_IDLE: begin
                if (b == CH_QUOTE) scan_state = SCAN_STR;
                else err = ERR_NO_QUOTE;
            end
            SCAN_STR: begin
                if (b == CH_QUOTE) begin
                    done = 1'b1;
                    scan_state = SCAN_IDLE;
                end else if (b == CH_BSLASH) begin
                    scan_state = SCAN_ESC;
                end else begin
                    dec[0] = b;
                    nb = 1;
                end
            end
            SCAN_ESC: begin
                scan_state = SCAN_STR;
                nb = 1;
                case (b)
                    "\"", "\\", "/": dec[0] = b;
                    "b": dec[0] = 8'h08;
                    "f": dec[0] = 8'h0C;
                    "n": dec[0] = 8'h0A;
                    "r": dec[0] = 8'h0D;
                    "t": dec[0] = 8'h09;
                    "u": begin
                        nb = 0;
                        scan_state = SCAN_HEX;
                        hex_taken = '0;
                        code_acc = '0;
                    end
                    default: begin
                        nb = 0;
                        err = ERR_ESCAPE;
                        scan_state = SCAN_IDLE;
                    end
                endcase
            end
            default: begin
                if (b >= "0" && b <= "9") digit = b - 8'h30;
                else if (b >= "a" && b <= "f") digit = b - 8'h57;
                else if (b >= "A" && b <= "F") digit = b - 8'h37;
                if (digit < 0) begin
                    err = ERR_HEX;
                    scan_state = SCAN_IDLE;
                end else begin
                    code_acc = {code_acc[11:0], 4'(digit)};
                    if (hex_taken == 2'd3) begin
                        // Four digits taken: emit the unit as UTF-8.
                        acc = code_acc;
                        if (acc < 16'h0080) begin
                            dec[0] = acc[7:0];
                            nb = 1;
                        end else if (acc < 16'h0800) begin
                            dec[0] = 8'hC0 | {3'b000, acc[10:6]};
                            dec[1] = 8'h80 | {2'b00, acc[5:0]};
                            nb = 2;
                        end else begin
                            dec[0] = 8'hE0 | {4'b0000, acc[15:12]};
                            dec[1] = 8'h80 | {2'b00, acc[11:6]};
                            dec[2] = 8'h80 | {2'b00, acc[5:0]};
                            nb = 3;
                        end
                        scan_state = SCAN_STR;
                        hex_taken = '0;
                        code_acc = '0;
                    end else begin
                        hex_taken = hex_taken + 2'd1;
                    end
                end
            end
        endcase

        // Text that stops inside a string is unterminated unless already in error.
        if (item.end_of_text && scan_state != SCAN_IDLE) begin
            if (err == ERR_NONE) err = ERR_UNTERM;
            scan_state = SCAN_IDLE;
        end

        cnt = nb;
        if (cnt == 0 && (done || err != ERR_NONE)) cnt = 1;
        for (int k = 0; k < cnt; k++) begin
            r = '0;
            if (k < nb) begin
                r.out_byte = dec[k];
                r.byte_valid = 1'b1;
            end
            if (k == cnt - 1) begin
                r.string_done = done;
                r.error_code = err;
                r.last = 1'b1;
            end
            decoded_q.push_back(r);
        end
    endfunction

    task automatic push_byte(logic [7:0] b, logic eot = 1'b0);
        in_t item;
        item.in_byte = b;
        item.end_of_text = eot;
        text_q.push_back(item);
    endtask

    task automatic push_chars(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    // Pushes a \u escape for one UTF-16 unit, hex letters in random case.
    task automatic push_unicode(logic [15:0] u);
        logic [3:0] nib;
        push_chars("\\u");
        for (int i = 3; i >= 0; i--) begin
            nib = u[i*4 +: 4];
            if (nib < 4'd10) push_byte(8'h30 + nib);
            else if ($urandom_range(0, 1)) push_byte(8'h41 + nib - 8'd10);
            else push_byte(8'h61 + nib - 8'd10);
        end
    endtask

    // One string with random content; most close cleanly, some break.
    task automatic push_random_string();
        string      esc_letters;
        int         pieces;
        int         ending;
        int         kind;
        logic [7:0] b;
        logic [15:0] u;
        esc_letters = "\"\\/bfnrt";
        push_byte(CH_QUOTE);
        pieces = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 8);
        for (int i = 0; i < pieces; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
                push_byte(b);
            end else if (kind < 8) begin
                push_byte(CH_BSLASH);
                push_byte(esc_letters[$urandom_range(0, 7)]);
            end else begin
                case ($urandom_range(0, 3))
                    0: u = 16'($urandom_range(0, 16'h007F));
                    1: u = 16'($urandom_range(16'h0080, 16'h07FF));
                    2: u = 16'($urandom_range(16'h0800, 16'hFFFF));
                    default: u = 16'($urandom_range(16'hD800, 16'hDFFF));
                endcase
                push_unicode(u);
            end
        end

        ending = $urandom_range(0, 19);
        if (ending < 12) begin
            push_byte(CH_QUOTE);
        end else if (ending < 15) begin
            push_byte(CH_QUOTE, 1'b1);
        end else if (ending == 15) begin
            // Escape letter outside the allowed set.
            do b = 8'($urandom_range(0, 255));
            while (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" ||
                   b == "n" || b == "r" || b == "t" || b == "u");
            push_byte(CH_BSLASH);
            push_byte(b, 1'($urandom_range(0, 1)));
        end else if (ending == 16) begin
            // Non-hex byte somewhere inside a \u escape.
            push_chars("\\u");
            for (int i = $urandom_range(0, 3); i > 0; i--)
                push_byte(8'("a" + $urandom_range(0, 5)));
            do b = 8'($urandom_range(0, 255)); while (is_hex_digit(b));
            push_byte(b, 1'($urandom_range(0, 1)));
        end else if (ending == 17) begin
            // Text stops partway through a \u escape.
            push_chars("\\u");
            for (int i = $urandom_range(1, 3); i > 1; i--)
                push_byte(8'("0" + $urandom_range(0, 9)));
            push_byte("F", 1'b1);
        end else begin
            // Text stops on a plain byte or a backslash inside the string.
            do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
            push_byte(b, 1'b1);
        end
    endtask

    // Input driver: holds each byte until its transfer, then idles at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_cnt <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_decoded(s_data);
            end
            if (!s_valid || s_ready) begin
                if (gap_cnt != 0) begin
                    gap_cnt <= gap_cnt - 1;
                    s_valid <= 1'b0;
                end else if (text_q.size() != 0) begin
                    s_data <= text_q.pop_front();
                    s_valid <= 1'b1;
                    in_draws++;
                    gap_cnt <= pick_delay(in_draws);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transfer and stalls the channel at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_cnt <= 0;
        end else if (m_valid && m_ready) begin
            if (decoded_q.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none predicted", result_count));
            end else begin
                want = decoded_q.pop_front();
                if (m_data.out_byte !== want.out_byte)
                    report_mismatch($sformatf("result %0d out_byte %h, predicted %h",
                                              result_count, m_data.out_byte, want.out_byte));
                if (m_data.byte_valid !== want.byte_valid)
                    report_mismatch($sformatf("result %0d byte_valid %b, predicted %b",
                                              result_count, m_data.byte_valid, want.byte_valid));
                if (m_data.string_done !== want.string_done)
                    report_mismatch($sformatf("result %0d string_done %b, predicted %b",
                                              result_count, m_data.string_done, want.string_done));
                if (m_data.error_code !== want.error_code)
                    report_mismatch($sformatf("result %0d error_code %0d, predicted %0d",
                                              result_count, m_data.error_code, want.error_code));
                if (m_data.last !== want.last)
                    report_mismatch($sformatf("result %0d last %b, predicted %b",
                                              result_count, m_data.last, want.last));
            end
            result_count++;
            out_draws++;
            next_hold = pick_delay(out_draws);
            hold_cnt <= next_hold;
            m_ready <= (next_hold == 0);
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready <= (hold_cnt == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        // A stray byte before any string.
        push_byte(8'hFF);
        // Raw extremes, a simple escape, one- and two-byte units, close at end of text.
        push_byte(CH_QUOTE);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_chars("\\n\\u007F\\u07e9");
        push_byte(CH_QUOTE, 1'b1);
        // Lone surrogate in three bytes, then an unknown escape.
        push_chars("\"\\uDbFf\\q");
        // Bad hex digit on the last byte of text keeps its own code.
        push_chars("\"\\uAbC");
        push_byte("g", 1'b1);
        // Text ends on a plain byte, then on a backslash.
        push_byte(CH_QUOTE);
        push_byte("x", 1'b1);
        push_byte(CH_QUOTE);
        push_byte(CH_BSLASH, 1'b1);

        // Random part: mostly strings, some stray bytes between them.
        while (text_q.size() < 530) begin
            if ($urandom_range(0, 6) == 0) begin
                for (int i = $urandom_range(1, 3); i > 0; i--)
                    push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0));
            end else begin
                push_random_string();
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (text_q.size() != 0 || s_valid || decoded_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (error_count == 0 && decoded_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
